// File: rtl/ctsf_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ctsf_pkg - shared definitions for the CRF talker timestamp framer
// Field widths, register indexes, reset values and the command/status
// bundles passed between the controller and the datapath.
// ----------------------------------------------------------------------------
package ctsf_pkg;

  // Frame length default
  localparam int FRAME_TIMESTAMPS_DEF = 6;

  // Field widths
  localparam int TS_W     = 64;
  localparam int PER_W    = 32;
  localparam int CFG_W    = 27;
  localparam int SLOT_W   = 3;
  localparam int M_DATA_W = 72;  // timestamp + slot, padded to whole bytes

  // Configuration registers
  localparam int CFG_IDX_W = 1;
  localparam logic [CFG_IDX_W-1:0] CFG_NOMINAL_PERIOD = 1'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_TRANSIT_OFFSET = 1'd1;

  localparam logic [CFG_W-1:0] NOMINAL_PERIOD_RESET = 27'd3333333;
  localparam logic [CFG_W-1:0] TRANSIT_OFFSET_RESET = 27'd2000000;

  // Datapath step commands from the controller
  typedef struct packed {
    logic load_edge;  // capture edge, form period since previous edge
    logic rd_en;      // registered buffer read
    logic do_mag;     // distance of period from nominal
    logic do_per;     // update measured period when within tolerance
    logic do_ts1;     // edge + offset, period multiple
    logic do_ts2;     // presentation time and expected time
    logic do_chk;     // difference to expected time
    logic do_abs;     // magnitude of that difference
    logic mem_we;     // append presentation time to the frame buffer
    logic load_out;   // load the output register from read data
    logic out_last;   // final entry of the frame
  } ctsf_cmd_t;

  // Datapath status back to the controller
  typedef struct packed {
    logic cont_ok;    // new time follows the previous entry within tolerance
  } ctsf_status_t;

endpackage

// File: rtl/ctsf_ctrl.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ctsf_ctrl - sequencing controller
// Steps each edge through the datapath, keeps the frame fill count and
// drains a full frame one transfer at a time.
// ----------------------------------------------------------------------------
module ctsf_ctrl
  import ctsf_pkg::*;
#(
  parameter int FRAME_TIMESTAMPS = FRAME_TIMESTAMPS_DEF,
  parameter int IDX_W            = $clog2(FRAME_TIMESTAMPS)
) (
  input  logic             clk,
  input  logic             rst,
  input  logic             s_tvalid,
  output logic             s_tready,
  output logic             m_tvalid,
  input  logic             m_tready,
  output ctsf_cmd_t        cmd,
  input  ctsf_status_t     st,
  output logic [IDX_W-1:0] rd_addr,
  output logic [IDX_W-1:0] wr_addr,
  output logic [IDX_W-1:0] slot_idx
);

  localparam int CNT_W = $clog2(FRAME_TIMESTAMPS + 1);
  localparam logic [IDX_W-1:0] LAST_IDX  = IDX_W'(FRAME_TIMESTAMPS - 1);
  localparam logic [CNT_W-1:0] LAST_FILL = CNT_W'(FRAME_TIMESTAMPS - 1);

  typedef enum logic [3:0] {
    S_IDLE, S_MAG, S_PER, S_TS1, S_TS2, S_CHK, S_ABS, S_TEST,
    S_RD, S_LOAD, S_SEND
  } state_t;

  state_t           state;
  logic [CNT_W-1:0] fill;
  logic [IDX_W-1:0] drain_idx;
  logic [IDX_W-1:0] prev_idx;
  logic             s_accept;
  logic             take;

  assign s_tready = (state == S_IDLE);
  assign s_accept = s_tvalid && s_tready;
  assign prev_idx = (fill == '0) ? '0 : IDX_W'(fill - 1'b1);
  // first entry of a frame is taken without a continuity test
  assign take     = (fill == '0) || st.cont_ok;
  assign wr_addr  = IDX_W'(fill);
  assign slot_idx = drain_idx;

  // Decode datapath commands from the state
  always_comb begin
    cmd     = '0;
    rd_addr = prev_idx;
    unique case (state)
      S_IDLE: begin
        cmd.load_edge = s_accept;
        cmd.rd_en     = s_accept;
      end
      S_MAG:  cmd.do_mag = 1'b1;
      S_PER:  cmd.do_per = 1'b1;
      S_TS1:  cmd.do_ts1 = 1'b1;
      S_TS2:  cmd.do_ts2 = 1'b1;
      S_CHK:  cmd.do_chk = 1'b1;
      S_ABS:  cmd.do_abs = 1'b1;
      S_TEST: cmd.mem_we = take;
      S_RD: begin
        cmd.rd_en = 1'b1;
        rd_addr   = drain_idx;
      end
      S_LOAD: begin
        cmd.load_out = 1'b1;
        cmd.out_last = (drain_idx == LAST_IDX);
      end
      S_SEND: ;
      default: ;
    endcase
  end

  // Hold state, fill count, drain index and output valid
  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_IDLE;
      fill      <= '0;
      drain_idx <= '0;
      m_tvalid  <= 1'b0;
    end else begin
      unique case (state)
        S_IDLE: if (s_accept) state <= S_MAG;
        S_MAG:  state <= S_PER;
        S_PER:  state <= S_TS1;
        S_TS1:  state <= S_TS2;
        S_TS2:  state <= S_CHK;
        S_CHK:  state <= S_ABS;
        S_ABS:  state <= S_TEST;
        S_TEST: begin
          if (!take) begin
            // drop the frame collected so far
            fill  <= '0;
            state <= S_IDLE;
          end else if (fill == LAST_FILL) begin
            fill      <= '0;
            drain_idx <= '0;
            state     <= S_RD;
          end else begin
            fill  <= fill + 1'b1;
            state <= S_IDLE;
          end
        end
        S_RD:   state <= S_LOAD;
        S_LOAD: begin
          m_tvalid <= 1'b1;
          state    <= S_SEND;
        end
        S_SEND: begin
          if (m_tready) begin
            m_tvalid <= 1'b0;
            if (drain_idx == LAST_IDX) begin
              state <= S_IDLE;
            end else begin
              drain_idx <= drain_idx + 1'b1;
              state     <= S_RD;
            end
          end
        end
        default: state <= S_IDLE;
      endcase
    end
  end

endmodule

// File: rtl/ctsf_datapath.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ctsf_datapath - period tracking, presentation time and frame buffer
// Holds the configuration registers, the previous edge, the measured period,
// the frame buffer memory and the output register.
// ----------------------------------------------------------------------------
module ctsf_datapath
  import ctsf_pkg::*;
#(
  parameter int FRAME_TIMESTAMPS = FRAME_TIMESTAMPS_DEF,
  parameter int IDX_W            = $clog2(FRAME_TIMESTAMPS)
) (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 cfg_we,
  input  logic [CFG_IDX_W-1:0] cfg_index,
  input  logic [CFG_W-1:0]     cfg_data,
  input  logic [TS_W-1:0]      edge_in,
  input  ctsf_cmd_t            cmd,
  output ctsf_status_t         st,
  input  logic [IDX_W-1:0]     rd_addr,
  input  logic [IDX_W-1:0]     wr_addr,
  input  logic [IDX_W-1:0]     slot_idx,
  output logic [TS_W-1:0]      out_ts,
  output logic [SLOT_W-1:0]    out_slot,
  output logic                 out_last
);

  localparam int MUL_W = PER_W + $clog2(FRAME_TIMESTAMPS);
  localparam int T27_W = CFG_W + 4;
  localparam int T32_W = PER_W + 4;

  logic [CFG_W-1:0] nominal;
  logic [CFG_W-1:0] offset;
  logic [TS_W-1:0]  prev_edge;
  logic [PER_W-1:0] meas_per;

  logic [TS_W-1:0]  edge_r;
  logic [TS_W-1:0]  cur_r;
  logic [TS_W-1:0]  mag_r;
  logic [TS_W-1:0]  part_r;
  logic [MUL_W-1:0] prod_r;
  logic [TS_W-1:0]  ts_r;
  logic [TS_W-1:0]  expect_r;
  logic [TS_W-1:0]  diff_r;
  logic [TS_W-1:0]  rd_data;
  logic [TS_W-1:0]  mem [FRAME_TIMESTAMPS];

  logic [TS_W-1:0]  nom64;
  logic [T27_W-1:0] ten27;
  logic [T32_W-1:0] ten32;
  logic             per_ok;

  assign nom64 = TS_W'(nominal);

  // Tolerance: |d| below the period and ten times |d| below the period
  assign ten27  = (T27_W'(mag_r[CFG_W-1:0]) << 3) + (T27_W'(mag_r[CFG_W-1:0]) << 1);
  assign per_ok = (mag_r < nom64) && (ten27 < T27_W'(nominal));

  assign ten32      = (T32_W'(mag_r[PER_W-1:0]) << 3) + (T32_W'(mag_r[PER_W-1:0]) << 1);
  assign st.cont_ok = (mag_r < TS_W'(meas_per)) && (ten32 < T32_W'(meas_per));

  // Configuration and tracked edge state
  always_ff @(posedge clk) begin
    if (rst) begin
      nominal   <= NOMINAL_PERIOD_RESET;
      offset    <= TRANSIT_OFFSET_RESET;
      prev_edge <= '0;
      meas_per  <= '0;
    end else begin
      if (cfg_we) begin
        unique case (cfg_index)
          CFG_NOMINAL_PERIOD: nominal <= cfg_data;
          CFG_TRANSIT_OFFSET: offset  <= cfg_data;
          default: ;
        endcase
      end
      if (cmd.load_edge) prev_edge <= edge_in;
      if (cmd.do_per && per_ok) meas_per <= cur_r[PER_W-1:0];
    end
  end

  // Arithmetic steps, frame buffer and output register
  always_ff @(posedge clk) begin
    if (cmd.load_edge) begin
      edge_r <= edge_in;
      cur_r  <= edge_in - prev_edge;
    end
    if (cmd.do_mag) begin
      mag_r <= (cur_r >= nom64) ? (cur_r - nom64) : (nom64 - cur_r);
    end
    if (cmd.do_ts1) begin
      part_r <= edge_r + TS_W'(offset);
      prod_r <= MUL_W'(meas_per) * MUL_W'(FRAME_TIMESTAMPS - 1);
    end
    if (cmd.do_ts2) begin
      ts_r     <= part_r + TS_W'(prod_r);
      expect_r <= rd_data + TS_W'(meas_per);
    end
    if (cmd.do_chk) diff_r <= ts_r - expect_r;
    if (cmd.do_abs) mag_r <= diff_r[TS_W-1] ? (TS_W'(0) - diff_r) : diff_r;
    if (cmd.rd_en) rd_data <= mem[rd_addr];
    if (cmd.mem_we) mem[wr_addr] <= ts_r;
    if (cmd.load_out) begin
      out_ts   <= rd_data;
      out_slot <= SLOT_W'(slot_idx);
      out_last <= cmd.out_last;
    end
  end

endmodule

// File: rtl/crf_talker_timestamp_framer_unit.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// crf_talker_timestamp_framer_unit - CRF talker timestamp framer
// Turns media clock edge times into presentation times and emits them in
// frames of FRAME_TIMESTAMPS entries once a continuous frame is collected.
// ----------------------------------------------------------------------------
// Edges: the controller steps each edge through seven datapath stages
//   after the transfer before s_tready returns; no new edge is taken before then.
// Results: a completing edge is tested, then the frame's first result is read
//   from the buffer and loaded before it is on offer; the frame then drains one
//   result at a time (buffer read, load, send), held while m_tready is low.
//   No edge is taken while draining.
// Reset: synchronous; clears fill count, previous edge and measured period,
//   and restores the register reset values. No clearing pass is needed.
module crf_talker_timestamp_framer_unit
  import ctsf_pkg::*;
#(
  parameter int FRAME_TIMESTAMPS = FRAME_TIMESTAMPS_DEF
) (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 cfg_we,
  input  logic [CFG_IDX_W-1:0] cfg_index,
  input  logic [CFG_W-1:0]     cfg_data,
  input  logic                 s_tvalid,
  output logic                 s_tready,
  input  logic [TS_W-1:0]      s_tdata,   // [63:0] edge_time_ns
  output logic                 m_tvalid,
  input  logic                 m_tready,
  output logic [M_DATA_W-1:0]  m_tdata,   // [63:0] frame_timestamp, [66:64] slot
  output logic                 m_tlast    // last_of_frame
);

  localparam int IDX_W = $clog2(FRAME_TIMESTAMPS);

  ctsf_cmd_t         cmd;
  ctsf_status_t      st;
  logic [IDX_W-1:0]  rd_addr;
  logic [IDX_W-1:0]  wr_addr;
  logic [IDX_W-1:0]  slot_idx;
  logic [TS_W-1:0]   out_ts;
  logic [SLOT_W-1:0] out_slot;

  ctsf_ctrl #(
    .FRAME_TIMESTAMPS (FRAME_TIMESTAMPS),
    .IDX_W            (IDX_W)
  ) u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .cmd      (cmd),
    .st       (st),
    .rd_addr  (rd_addr),
    .wr_addr  (wr_addr),
    .slot_idx (slot_idx)
  );

  ctsf_datapath #(
    .FRAME_TIMESTAMPS (FRAME_TIMESTAMPS),
    .IDX_W            (IDX_W)
  ) u_datapath (
    .clk       (clk),
    .rst       (rst),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .edge_in   (s_tdata),
    .cmd       (cmd),
    .st        (st),
    .rd_addr   (rd_addr),
    .wr_addr   (wr_addr),
    .slot_idx  (slot_idx),
    .out_ts    (out_ts),
    .out_slot  (out_slot),
    .out_last  (m_tlast)
  );

  // Pack the result fields
  assign m_tdata = {(M_DATA_W - TS_W - SLOT_W)'(0), out_slot, out_ts};

  // Never take an edge while a result is on offer
  a_no_overlap : assert property (@(posedge clk) disable iff (rst)
    !(s_tready && m_tvalid))
    else $error("edge accepted while a result is pending");

  // An accepted edge occupies the block on the next cycle
  a_busy_after_accept : assert property (@(posedge clk) disable iff (rst)
    (s_tvalid && s_tready) |=> (!s_tready && !m_tvalid))
    else $error("block not busy after edge transfer");

  // The final transfer of a frame returns the block to accepting edges
  a_idle_after_last : assert property (@(posedge clk) disable iff (rst)
    (m_tvalid && m_tready && m_tlast) |=> (s_tready && !m_tvalid))
    else $error("block not ready after last transfer of frame");

endmodule
